>>> sv/leg_pkg.sv
`timescale 1ns / 1ps

package leg_pkg;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_DEL   = 8'h2D;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOVE = 5'b00010,
    ST_READ = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd_left;
    logic rd_right;
    logic rd_pos;
    logic pop;
    logic mv_wr;
    logic load;
    logic load_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic left_zero;
    logic right_zero;
    logic empty;
    logic out_last;
  } status_t;

endpackage

>>> sv/leg_ram.sv
`timescale 1ns / 1ps

module leg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/leg_ctrl.sv
`timescale 1ns / 1ps

module leg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  input  logic [7:0]       key_code,
  input  logic             m_tready,
  input  leg_pkg::status_t st,
  output logic             s_tready,
  output logic             m_tvalid,
  output leg_pkg::cmd_t    cmd
);

  leg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= leg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      leg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tlast) begin
            if (st.empty) begin
              cmd.load_empty = 1'b1;
              state_next     = leg_pkg::ST_SEND;
            end else begin
              state_next = leg_pkg::ST_READ;
            end
          end else if (key_code == leg_pkg::KEY_LEFT) begin
            if (!st.left_zero) begin
              cmd.rd_left = 1'b1;
              state_next  = leg_pkg::ST_MOVE;
            end
          end else if (key_code == leg_pkg::KEY_RIGHT) begin
            if (!st.right_zero) begin
              cmd.rd_right = 1'b1;
              state_next   = leg_pkg::ST_MOVE;
            end
          end else if (key_code == leg_pkg::KEY_DEL) begin
            cmd.del = 1'b1;
          end else begin
            cmd.ins = 1'b1;
          end
        end
      end
      leg_pkg::ST_MOVE: begin
        cmd.mv_wr  = 1'b1;
        state_next = leg_pkg::ST_IDLE;
      end
      leg_pkg::ST_READ: begin
        cmd.rd_pos = 1'b1;
        state_next = leg_pkg::ST_LOAD;
      end
      leg_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = leg_pkg::ST_SEND;
      end
      leg_pkg::ST_SEND: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (st.out_last) begin
            cmd.clear  = 1'b1;
            state_next = leg_pkg::ST_IDLE;
          end else begin
            cmd.pop    = 1'b1;
            cmd.rd_pos = 1'b1;
            state_next = leg_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = leg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/leg_dp.sv
`timescale 1ns / 1ps

module leg_dp #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  leg_pkg::cmd_t    cmd,
  input  logic [7:0]       key_code,
  output leg_pkg::status_t st,
  output logic [7:0]       char_out,
  output logic             char_valid,
  output logic             last,
  output logic             overflow
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP   = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_M = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] ONE   = CW'(1);

  logic [CW-1:0] left, right, pos;
  logic          dir_left;
  logic          ovf;

  logic [CW-1:0] total, gap, pos_rd, addr_pos;
  logic          full;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  assign total    = left + right;
  assign gap      = CAP - total;
  assign full     = (total == CAP);
  assign pos_rd   = cmd.pop ? pos + ONE : pos;
  assign addr_pos = (pos_rd < left) ? pos_rd : pos_rd + gap;

  always_comb begin
    priority if (cmd.rd_left) begin
      raddr = AW'(left - ONE);
    end else if (cmd.rd_right) begin
      raddr = AW'(CAP - right);
    end else if (cmd.rd_pos) begin
      raddr = addr_pos[AW-1:0];
    end else begin
      raddr = left[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = left[AW-1:0];
    wdata = key_code;
    if (cmd.ins && !full) begin
      we = 1'b1;
    end else if (cmd.mv_wr) begin
      we    = 1'b1;
      wdata = rdata;
      waddr = dir_left ? AW'(CAP_M - right) : left[AW-1:0];
    end
  end

  leg_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= '0;
      right <= '0;
      pos   <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      left  <= '0;
      right <= '0;
      pos   <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.ins) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          left <= left + ONE;
        end
      end
      if (cmd.del && left != '0) begin
        left <= left - ONE;
      end
      if (cmd.mv_wr) begin
        if (dir_left) begin
          left  <= left - ONE;
          right <= right + ONE;
        end else begin
          left  <= left + ONE;
          right <= right - ONE;
        end
      end
      if (cmd.pop) begin
        pos <= pos + ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_left) begin
      dir_left <= 1'b1;
    end else if (cmd.rd_right) begin
      dir_left <= 1'b0;
    end
    if (cmd.load) begin
      char_out   <= rdata;
      char_valid <= 1'b1;
      last       <= (pos + ONE == total);
    end else if (cmd.load_empty) begin
      char_out   <= '0;
      char_valid <= 1'b0;
      last       <= 1'b1;
    end
  end

  assign overflow      = ovf;
  assign st.left_zero  = (left == '0);
  assign st.right_zero = (right == '0);
  assign st.empty      = (total == '0);
  assign st.out_last   = last;

endmodule

>>> sv/line_edit_gap_buffer.sv
`timescale 1ns / 1ps
// Keystroke line editor, gap buffer of CAPACITY bytes in one RAM.
// Input beats: s_tdata = key code, s_tlast = end of line. With s_tlast low
// the key is 0x3C cursor left, 0x3E cursor right, 0x2D backspace, otherwise
// an insert. With s_tlast high the edited line is sent and the line cleared.
// Output beats, one per character: m_tdata = character, m_tuser[0] = char
// valid, m_tuser[1] = overflow (an insert was dropped on a full line),
// m_tlast on the final character. An empty line gives one beat with char
// valid low and m_tlast high.
// Insert and backspace complete on acceptance; a cursor move does a RAM read,
// then a RAM write in ST_MOVE, through the single registered read port.
// End of line: ST_READ, then ST_LOAD and ST_SEND per character (registered RAM
// read feeding the output register); the next is loaded once a beat is taken.
// Empty line: the result beat is presented in the cycle after acceptance.
// s_tready is low while a move or a line readout is in progress. A stalled
// m_tready holds the current beat and the readout waits with it.
// Reset clears the cursor, counts, overflow flag and handshake state; the
// RAM contents are not cleared.

module line_edit_gap_buffer #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] key_code
  input  logic       s_tlast,   // cmd: end of line
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic [1:0] m_tuser,   // [0] char_valid, [1] overflow
  output logic       m_tlast    // last
);

  leg_pkg::cmd_t    cmd;
  leg_pkg::status_t st;
  logic             char_valid, overflow;

  leg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .key_code (s_tdata),
    .m_tready (m_tready),
    .st       (st),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  leg_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .key_code   (s_tdata),
    .st         (st),
    .char_out   (m_tdata),
    .char_valid (char_valid),
    .last       (m_tlast),
    .overflow   (overflow)
  );

  assign m_tuser = {overflow, char_valid};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result beat is pending");

  a_ready_after_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not ready after the final beat of a line");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty-line beat without last");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !overflow)
    else $error("overflow flag not cleared at end of line");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CAP = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       lst;
    logic       ovf;
  } line_beat_t;

  typedef struct packed {
    logic       eol;
    logic [7:0] key;
    logic       typed;
    line_beat_t want;
  } key_row_t;

  localparam line_beat_t NO_BEAT = '0;
  localparam int N_ROWS = 25;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  line_edit_gap_buffer #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // editor shadow
  logic [7:0] text_mem [CAP];
  int         left_n;
  int         right_n;
  logic       ovf_flag;
  line_beat_t line_q[$];

  int errors;
  int send_idle;
  int rx_stall;
  int sent_keys;

  key_row_t dir_rows [N_ROWS];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("line_edit_gap_buffer verification failed");
    $finish;
  end

  task automatic edit_line(input logic eol, input logic [7:0] key);
    int i;
    int total;
    total = left_n + right_n;
    if (!eol) begin
      case (key)
        leg_pkg::KEY_LEFT: if (left_n > 0) begin
          text_mem[CAP - 1 - right_n] = text_mem[left_n - 1];
          left_n--;
          right_n++;
        end
        leg_pkg::KEY_RIGHT: if (right_n > 0) begin
          text_mem[left_n] = text_mem[CAP - right_n];
          left_n++;
          right_n--;
        end
        leg_pkg::KEY_DEL: if (left_n > 0) left_n--;
        default: if (total < CAP) begin
          text_mem[left_n] = key;
          left_n++;
        end else begin
          ovf_flag = 1'b1;
        end
      endcase
    end else begin
      if (total == 0) begin
        line_q.push_back('{8'h00, 1'b0, 1'b1, ovf_flag});
      end else begin
        for (i = 0; i < left_n; i++)
          line_q.push_back('{text_mem[i], 1'b1, (i + 1 == total), ovf_flag});
        for (i = 0; i < right_n; i++)
          line_q.push_back('{text_mem[CAP - right_n + i], 1'b1,
                             (left_n + i + 1 == total), ovf_flag});
      end
      left_n = 0;
      right_n = 0;
      ovf_flag = 1'b0;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_key(input logic eol, input logic [7:0] key, input logic typed,
                          input line_beat_t want);
    int gap;
    int n;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = line_q.size();
    edit_line(eol, key);
    if (typed) begin
      while (line_q.size() > n) void'(line_q.pop_back());
      line_q.push_back(want);
    end
    sent_keys++;
    @(negedge clk);
  endtask

  task automatic type_line(input int len, input int ins_pct);
    int k;
    int pick;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < ins_pct)
        send_key(1'b0, 8'($urandom_range(255)), 1'b0, NO_BEAT);
      else if (pick < ins_pct + (100 - ins_pct) * 4 / 10)
        send_key(1'b0, leg_pkg::KEY_LEFT, 1'b0, NO_BEAT);
      else if (pick < ins_pct + (100 - ins_pct) * 8 / 10)
        send_key(1'b0, leg_pkg::KEY_RIGHT, 1'b0, NO_BEAT);
      else
        send_key(1'b0, leg_pkg::KEY_DEL, 1'b0, NO_BEAT);
    end
    send_key(1'b1, 8'($urandom_range(255)), 1'b0, NO_BEAT);
  endtask

  task automatic drain_lines();
    s_tvalid <= 1'b0;
    while (line_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_stall);

  always @(posedge clk) begin
    line_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (line_q.size() == 0) begin
        $error("char_out: expected no beat, got %0h", m_tdata);
        errors++;
      end else begin
        want = line_q.pop_front();
        check_field("char_out", want.ch, m_tdata);
        check_field("char_valid", want.vld, m_tuser[0]);
        check_field("last", want.lst, m_tlast);
        check_field("overflow", want.ovf, m_tuser[1]);
      end
    end
  end

  initial begin
    int r;
    int ph;
    int len;
    int ins_pct;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    errors = 0;
    send_idle = 0;
    rx_stall = 0;
    sent_keys = 0;
    left_n = 0;
    right_n = 0;
    ovf_flag = 1'b0;

    dir_rows = '{
      '{1'b1, 8'h00,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},  // empty line after reset
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},            // left at start
      '{1'b0, leg_pkg::KEY_RIGHT, 1'b0, NO_BEAT},            // right at end
      '{1'b0, leg_pkg::KEY_DEL,   1'b0, NO_BEAT},            // delete at start
      '{1'b1, 8'hFF,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      '{1'b0, 8'h00,     1'b0, NO_BEAT},
      '{1'b1, 8'h55,     1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 8'hFF,     1'b0, NO_BEAT},
      '{1'b1, 8'hAA,     1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 8'h3B,     1'b0, NO_BEAT},
      '{1'b0, 8'h3D,     1'b0, NO_BEAT},
      '{1'b0, 8'h2C,     1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, 8'h2E,     1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_RIGHT, 1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_DEL,   1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},
      '{1'b0, leg_pkg::KEY_DEL,   1'b0, NO_BEAT},            // delete at start, text to right
      '{1'b0, leg_pkg::KEY_RIGHT, 1'b0, NO_BEAT},
      '{1'b1, leg_pkg::KEY_LEFT,  1'b0, NO_BEAT},            // key ignored on end of line
      '{1'b1, 8'h00,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < N_ROWS; r++)
      send_key(dir_rows[r].eol, dir_rows[r].key, dir_rows[r].typed, dir_rows[r].want);
    drain_lines();

    // full line plus dropped inserts
    type_line(CAP + 4, 100);
    drain_lines();

    for (ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 37) : 0;
      rx_stall  = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 37) : 0;
      sent_keys = 0;
      while (sent_keys < 15) begin
        if ($urandom_range(11) == 0) begin
          len = $urandom_range(CAP - 4, CAP + 8);
          ins_pct = 95;
        end else begin
          len = $urandom_range(0, 12);
          ins_pct = ($urandom_range(99) < 85) ? 60 : 20;
        end
        type_line(len, ins_pct);
      end
      drain_lines();
    end

    rx_stall = 0;
    repeat (20) @(negedge clk);
    if (errors == 0)
      $display("line_edit_gap_buffer verification clean");
    else
      $display("line_edit_gap_buffer verification failed");
    $finish;
  end

endmodule
